// File: rtl/core/serial_message_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Serial message framer assertion macros
// Shared property macros for the framer core checks.
// ----------------------------------------------------------------------------
`ifndef SERIAL_MESSAGE_FRAMER_CORE_MACROS_SVH
`define SERIAL_MESSAGE_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the core clock, muted during reset.
`define SMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the core clock, muted during reset.
`define SMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/smf_pkg.sv
// ----------------------------------------------------------------------------
// Serial message framer package
// Types, constants and hex decode helpers shared by the framer modules.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int BUF_DEPTH       = 28;
  localparam int RADIO_FRAME_LEN = 14;
  localparam int HIST_DEPTH      = 11;
  localparam int MAX_PAYLOAD     = 24;
  localparam int TDATA_W         = 120;

  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_B  = 8'h62;
  localparam logic [7:0] CH_H  = 8'h68;
  localparam logic [7:0] CH_I  = 8'h69;
  localparam logic [7:0] CH_L  = 8'h6c;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] SYNC0 = 8'hA5;
  localparam logic [7:0] SYNC1 = 8'h5A;

  typedef enum logic [2:0] {
    MSG_NONE       = 3'd0,
    MSG_BOOT_ACK   = 3'd1,
    MSG_BOOT_HEX   = 3'd2,
    MSG_BOOT_START = 3'd3,
    MSG_LIGHT_SET  = 3'd4,
    MSG_ALIVE      = 3'd5,
    MSG_RADIO      = 3'd6
  } msg_type_t;

  // Declared from the highest field down so that message_type sits at bit 0.
  typedef struct packed {
    logic [7:0]  status_byte;
    logic [31:0] sender_id;
    logic [31:0] data_word;
    logic [7:0]  org_byte;
    logic [4:0]  telegram_length;
    logic [2:0]  sequence_bits;
    logic        checksum_ok;
    logic [7:0]  second_number;
    logic [7:0]  first_number;
    logic [4:0]  frame_position;
    msg_type_t   message_type;
  } result_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      v = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] h;
    logic [7:0] l;
    h = digit_value(hi);
    l = digit_value(lo);
    return {h[3:0], 4'h0} + l;
  endfunction

endpackage

// File: rtl/core/serial_message_framer_core.sv
// ----------------------------------------------------------------------------
// Serial message framer core
// Frames received serial bytes into command messages or radio telegrams.
// ----------------------------------------------------------------------------
// Each input transaction on in_* carries one received byte. Every byte
// produces exactly one output transaction on out_*, which reports either the
// running frame position or, on the last byte of a frame, the decoded message.
// The cfg_* channel writes the protocol mode (0 command text, 1 radio
// telegram); it is always ready and should only be used while no bytes are in
// flight. A mode write abandons any partial frame.
// A byte's result appears on out_tvalid once it has passed both registers: the
// input register captures the byte, and the decode logic writes the result
// register when that register can take it. One byte is taken per cycle while the
// receiver keeps up, since the frame state's next value is computed
// combinationally between those two registers.
// When out_tready is low the result register holds its transaction, the input
// register fills, and in_tready then drops until the receiver takes the result.
// After reset both registers are empty, the mode is command framing and no
// frame is in progress.
// ----------------------------------------------------------------------------
`include "serial_message_framer_core_macros.svh"

module serial_message_framer_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata: rx_byte[7:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,
  // tdata: message_type[2:0], frame_position[7:3], first_number[15:8],
  // second_number[23:16], checksum_ok[24], sequence_bits[27:25],
  // telegram_length[32:28], org_byte[40:33], data_word[72:41],
  // sender_id[104:73], status_byte[112:105], zero fill[119:113]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [smf_pkg::TDATA_W-1:0] out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_data
);

  logic             take;
  logic             stage_valid;
  logic [7:0]       stage_byte;
  logic             step;
  logic             cfg_we;
  logic [4:0]       position;
  smf_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign step      = stage_valid & take;

  smf_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  smf_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .rx_byte  (stage_byte),
    .cfg_we   (cfg_we),
    .cfg_mode (cfg_data),
    .result   (result),
    .position (position)
  );

  smf_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .result     (result),
    .can_load   (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `SMF_ASSERT_SAME(a_done_clears_position,
    out_tvalid && out_tdata[2:0] != smf_pkg::MSG_NONE, out_tdata[7:3] == 5'd0,
    "Completed message reports a nonzero frame position.")

  `SMF_ASSERT_SAME(a_radio_fields_only_on_radio,
    out_tvalid && out_tdata[2:0] != smf_pkg::MSG_RADIO,
    out_tdata[24] == 1'b0 && out_tdata[112:105] == 8'd0,
    "Radio fields are set on a result that is not a radio telegram.")

  `SMF_ASSERT_NEXT(a_step_loads_result, step, out_tvalid,
    "A processed byte did not produce a pending result.")

  `SMF_ASSERT_NEXT(a_position_bounded, step, position <= 5'(smf_pkg::BUF_DEPTH),
    "Frame position ran past the buffer depth.")

endmodule

// File: rtl/core/smf_in_stage.sv
// ----------------------------------------------------------------------------
// Serial message framer input stage
// Registers one received byte and hands it to the frame engine.
// ----------------------------------------------------------------------------
module smf_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       advance;
  logic       in_fire;

  assign advance   = valid_r & take;
  assign in_tready = ~valid_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_tdata;
    end
  end

  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;

endmodule

// File: rtl/core/smf_engine.sv
// ----------------------------------------------------------------------------
// Serial message framer engine
// Holds the frame state and turns one byte into one result per step.
// ----------------------------------------------------------------------------
module smf_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             cfg_we,
  input  logic             cfg_mode,
  output smf_pkg::result_t result,
  output logic [4:0]       position
);

  logic                   mode_r, mode_nxt;
  logic [4:0]             position_r, position_nxt;
  smf_pkg::msg_type_t     kind_r, kind_nxt;
  logic [4:0]             exp_len_r, exp_len_nxt;
  logic [7:0]             num_r [2];
  logic [7:0]             num_nxt [2];
  logic [7:0]             sum_r, sum_nxt;
  logic [7:0]             hist_r [smf_pkg::HIST_DEPTH];
  logic [4:0]             pos;
  logic [7:0]             pair;
  logic                   reject;
  logic                   done;

  assign pos  = position_r + 5'd1;
  assign pair = smf_pkg::hex_pair(hist_r[0], rx_byte);

  always_comb begin
    mode_nxt     = mode_r;
    position_nxt = position_r;
    kind_nxt     = kind_r;
    exp_len_nxt  = exp_len_r;
    num_nxt[0]   = num_r[0];
    num_nxt[1]   = num_r[1];
    sum_nxt      = sum_r;
    reject       = 1'b0;
    done         = 1'b0;
    result       = '0;

    if (step) begin
      if (pos > 5'(smf_pkg::BUF_DEPTH)) begin
        position_nxt = '0;
      end else begin
        if (!mode_r) begin
          if (pos == 5'd1) begin
            reject = !(rx_byte == smf_pkg::CH_B || rx_byte == smf_pkg::CH_L ||
                       rx_byte == smf_pkg::CH_I);
            num_nxt[0] = '0;
            num_nxt[1] = '0;
          end else if (pos == 5'd2) begin
            if (hist_r[0] == smf_pkg::CH_B && rx_byte == smf_pkg::CH_A) begin
              kind_nxt    = smf_pkg::MSG_BOOT_ACK;
              exp_len_nxt = 5'd2;
            end else if (hist_r[0] == smf_pkg::CH_B && rx_byte == smf_pkg::CH_H) begin
              kind_nxt    = smf_pkg::MSG_BOOT_HEX;
              exp_len_nxt = 5'd4;
            end else if (hist_r[0] == smf_pkg::CH_B && rx_byte == smf_pkg::CH_S) begin
              kind_nxt    = smf_pkg::MSG_BOOT_START;
              exp_len_nxt = 5'd4;
            end else if (hist_r[0] == smf_pkg::CH_L && rx_byte == smf_pkg::CH_S) begin
              kind_nxt    = smf_pkg::MSG_LIGHT_SET;
              exp_len_nxt = 5'd6;
            end else if (hist_r[0] == smf_pkg::CH_I && rx_byte == smf_pkg::CH_A) begin
              kind_nxt    = smf_pkg::MSG_ALIVE;
              exp_len_nxt = 5'd2;
            end else begin
              reject = 1'b1;
            end
          end else if (pos == 5'd4) begin
            num_nxt[0] = pair;
            if (kind_r == smf_pkg::MSG_BOOT_HEX) begin
              if (pair > 8'(smf_pkg::MAX_PAYLOAD) || pair > 8'(smf_pkg::BUF_DEPTH - 4)) begin
                reject = 1'b1;
              end else begin
                exp_len_nxt = 5'd4 + pair[4:0];
              end
            end
          end else if (pos == 5'd6) begin
            num_nxt[1] = pair;
          end
          if (!reject && pos > 5'd1 && pos == exp_len_nxt) begin
            done                  = 1'b1;
            result.message_type   = kind_nxt;
            result.first_number   = num_nxt[0];
            result.second_number  = num_nxt[1];
          end
        end else begin
          if (pos == 5'd1) begin
            reject = (rx_byte != smf_pkg::SYNC0);
          end else if (pos == 5'd2) begin
            if (rx_byte != smf_pkg::SYNC1) begin
              reject = 1'b1;
            end else begin
              kind_nxt    = smf_pkg::MSG_RADIO;
              exp_len_nxt = 5'(smf_pkg::RADIO_FRAME_LEN);
              sum_nxt     = '0;
            end
          end else if (pos < 5'(smf_pkg::RADIO_FRAME_LEN)) begin
            sum_nxt = sum_r + rx_byte;
          end
          // The history line holds telegram bytes three to thirteen, newest first.
          if (!reject && pos == 5'(smf_pkg::RADIO_FRAME_LEN)) begin
            done                   = 1'b1;
            result.message_type    = smf_pkg::MSG_RADIO;
            result.checksum_ok     = (sum_r == rx_byte);
            result.sequence_bits   = hist_r[10][7:5];
            result.telegram_length = hist_r[10][4:0];
            result.org_byte        = hist_r[9];
            result.data_word       = {hist_r[8], hist_r[7], hist_r[6], hist_r[5]};
            result.sender_id       = {hist_r[4], hist_r[3], hist_r[2], hist_r[1]};
            result.status_byte     = hist_r[0];
          end
        end

        if (done || reject) begin
          position_nxt = '0;
        end else begin
          position_nxt          = pos;
          result.frame_position = pos;
        end
      end
    end

    if (cfg_we) begin
      mode_nxt     = cfg_mode;
      position_nxt = '0;
      sum_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      position_r <= '0;
      kind_r     <= smf_pkg::MSG_NONE;
      exp_len_r  <= '0;
      num_r[0]   <= '0;
      num_r[1]   <= '0;
      sum_r      <= '0;
    end else begin
      mode_r     <= mode_nxt;
      position_r <= position_nxt;
      kind_r     <= kind_nxt;
      exp_len_r  <= exp_len_nxt;
      num_r[0]   <= num_nxt[0];
      num_r[1]   <= num_nxt[1];
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      hist_r[0] <= rx_byte;
      for (int i = 1; i < smf_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign position = position_r;

endmodule

// File: rtl/core/smf_out_stage.sv
// ----------------------------------------------------------------------------
// Serial message framer output stage
// Result register that holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module smf_out_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  smf_pkg::result_t               result,
  output logic                           can_load,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [smf_pkg::TDATA_W-1:0]    out_tdata
);

  logic             valid_r;
  logic             valid_nxt;
  smf_pkg::result_t data_r;

  assign can_load = ~valid_r | out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(smf_pkg::TDATA_W - $bits(smf_pkg::result_t))'(0), data_r};

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Serial message framer core testbench
// Feeds received bytes in command and radio framing modes, predicts every
// result transaction in step with the input and compares it field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int RES_W = $bits(smf_pkg::result_t);

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata = 8'h00;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [smf_pkg::TDATA_W-1:0] out_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic                        cfg_data = 1'b0;

  serial_message_framer_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [7:0]         rx_pending[$];
  smf_pkg::result_t   frame_results[$];
  int                 errors = 0;

  logic               fr_mode = 1'b0;
  logic [4:0]         fr_pos = '0;
  smf_pkg::msg_type_t fr_kind = smf_pkg::MSG_NONE;
  logic [4:0]         fr_len = '0;
  logic [7:0]         fr_buf [smf_pkg::BUF_DEPTH] = '{default: 8'h00};
  logic [7:0]         fr_num [2] = '{default: 8'h00};
  logic [7:0]         fr_sum = '0;

  int burst_left = 8;
  int gap_left = 0;
  int stall_style = 0;
  int stall_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 40) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    end
    errors++;
  endtask

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h37;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h57;
    return c;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    return 8'(16 * int'(digit_of(hi)) + int'(digit_of(lo)));
  endfunction

  function automatic smf_pkg::result_t frame_next_result(input logic [7:0] rx);
    smf_pkg::result_t r;
    int               p;
    logic             drop;
    logic [7:0]       n;
    r = '0;
    p = int'(fr_pos) + 1;
    drop = 1'b0;
    if (p > smf_pkg::BUF_DEPTH) begin
      fr_pos = '0;
      return r;
    end
    fr_buf[p-1] = rx;
    if (!fr_mode) begin
      if (p == 1) begin
        if (rx != smf_pkg::CH_B && rx != smf_pkg::CH_L && rx != smf_pkg::CH_I) drop = 1'b1;
        fr_num[0] = '0;
        fr_num[1] = '0;
      end else if (p == 2) begin
        case ({fr_buf[0], rx})
          {smf_pkg::CH_B, smf_pkg::CH_A}: begin
            fr_kind = smf_pkg::MSG_BOOT_ACK;
            fr_len = 5'd2;
          end
          {smf_pkg::CH_B, smf_pkg::CH_H}: begin
            fr_kind = smf_pkg::MSG_BOOT_HEX;
            fr_len = 5'd4;
          end
          {smf_pkg::CH_B, smf_pkg::CH_S}: begin
            fr_kind = smf_pkg::MSG_BOOT_START;
            fr_len = 5'd4;
          end
          {smf_pkg::CH_L, smf_pkg::CH_S}: begin
            fr_kind = smf_pkg::MSG_LIGHT_SET;
            fr_len = 5'd6;
          end
          {smf_pkg::CH_I, smf_pkg::CH_A}: begin
            fr_kind = smf_pkg::MSG_ALIVE;
            fr_len = 5'd2;
          end
          default: drop = 1'b1;
        endcase
      end else if (p == 4) begin
        n = pair_value(fr_buf[2], fr_buf[3]);
        fr_num[0] = n;
        if (fr_kind == smf_pkg::MSG_BOOT_HEX) begin
          if (n > smf_pkg::MAX_PAYLOAD || n > smf_pkg::BUF_DEPTH - 4) drop = 1'b1;
          else fr_len = 5'(4 + n);
        end
      end else if (p == 6) begin
        fr_num[1] = pair_value(fr_buf[4], fr_buf[5]);
      end
      if (!drop && p > 1 && p == int'(fr_len)) begin
        fr_pos = '0;
        r.message_type = fr_kind;
        r.first_number = fr_num[0];
        r.second_number = fr_num[1];
        return r;
      end
    end else begin
      if (p == 1) begin
        if (rx != smf_pkg::SYNC0) drop = 1'b1;
      end else if (p == 2) begin
        if (rx != smf_pkg::SYNC1) begin
          drop = 1'b1;
        end else begin
          fr_kind = smf_pkg::MSG_RADIO;
          fr_len = 5'(smf_pkg::RADIO_FRAME_LEN);
          fr_sum = '0;
        end
      end else if (p < smf_pkg::RADIO_FRAME_LEN) begin
        fr_sum = fr_sum + rx;
      end
      if (!drop && p == smf_pkg::RADIO_FRAME_LEN) begin
        fr_pos = '0;
        r.message_type = smf_pkg::MSG_RADIO;
        r.checksum_ok = (fr_sum == rx);
        r.sequence_bits = fr_buf[2][7:5];
        r.telegram_length = fr_buf[2][4:0];
        r.org_byte = fr_buf[3];
        r.data_word = {fr_buf[4], fr_buf[5], fr_buf[6], fr_buf[7]};
        r.sender_id = {fr_buf[8], fr_buf[9], fr_buf[10], fr_buf[11]};
        r.status_byte = fr_buf[12];
        return r;
      end
    end
    if (drop) begin
      fr_pos = '0;
      return r;
    end
    fr_pos = 5'(p);
    r.frame_position = 5'(p);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'h00;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_results.push_back(frame_next_result(in_tdata));
        void'(rx_pending.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          burst_left = $urandom_range(1, 40);
        end
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= rx_pending[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    smf_pkg::result_t got;
    smf_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = smf_pkg::result_t'(out_tdata[RES_W-1:0]);
        if (frame_results.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata[63:0], '0);
        end else begin
          want = frame_results.pop_front();
          if (got.message_type !== want.message_type)
            report_mismatch("message_type", got.message_type, want.message_type);
          if (got.frame_position !== want.frame_position)
            report_mismatch("frame_position", got.frame_position, want.frame_position);
          if (got.first_number !== want.first_number)
            report_mismatch("first_number", got.first_number, want.first_number);
          if (got.second_number !== want.second_number)
            report_mismatch("second_number", got.second_number, want.second_number);
          if (got.checksum_ok !== want.checksum_ok)
            report_mismatch("checksum_ok", got.checksum_ok, want.checksum_ok);
          if (got.sequence_bits !== want.sequence_bits)
            report_mismatch("sequence_bits", got.sequence_bits, want.sequence_bits);
          if (got.telegram_length !== want.telegram_length)
            report_mismatch("telegram_length", got.telegram_length, want.telegram_length);
          if (got.org_byte !== want.org_byte)
            report_mismatch("org_byte", got.org_byte, want.org_byte);
          if (got.data_word !== want.data_word)
            report_mismatch("data_word", got.data_word, want.data_word);
          if (got.sender_id !== want.sender_id)
            report_mismatch("sender_id", got.sender_id, want.sender_id);
          if (got.status_byte !== want.status_byte)
            report_mismatch("status_byte", got.status_byte, want.status_byte);
          if (out_tdata[smf_pkg::TDATA_W-1:RES_W] !== '0)
            report_mismatch("zero fill", out_tdata[smf_pkg::TDATA_W-1:RES_W], '0);
        end
      end
      stall_count++;
      if (stall_count >= 48) begin
        stall_count = 0;
        stall_style = $urandom_range(0, 4);
      end
      case (stall_style)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= 1'($urandom_range(0, 1));
        3: out_tready <= (stall_count % 8 < 5);
        default: out_tready <= (stall_count >= 36);
      endcase
    end
  end

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_pending.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic push_number(input int v, output logic [7:0] val);
    logic [7:0] hi;
    logic [7:0] lo;
    if (v < 0) begin
      hi = 8'($urandom_range(0, 255));
      lo = 8'($urandom_range(0, 255));
    end else begin
      hi = hex_char(v[7:4]);
      lo = hex_char(v[3:0]);
    end
    rx_pending.push_back(hi);
    rx_pending.push_back(lo);
    val = pair_value(hi, lo);
  endtask

  task automatic push_random_bytes(input int count);
    for (int i = 0; i < count; i++) rx_pending.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_telegram(input int fill, input bit good_sum);
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    rx_pending.push_back(smf_pkg::SYNC0);
    rx_pending.push_back(smf_pkg::SYNC1);
    for (int i = 0; i < smf_pkg::RADIO_FRAME_LEN - 3; i++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      sum = sum + b;
      rx_pending.push_back(b);
    end
    rx_pending.push_back(good_sum ? sum : 8'(sum + $urandom_range(1, 255)));
  endtask

  task automatic push_command_frame();
    logic [7:0] cnt;
    logic [7:0] unused;
    int         r;
    case ($urandom_range(0, 4))
      0: push_text("ba");
      1: push_text("ia");
      2: begin
        push_text("bs");
        push_number(($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 255), unused);
      end
      3: begin
        push_text("ls");
        push_number(($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 255), unused);
        push_number(($urandom_range(0, 7) == 0) ? -1 : $urandom_range(0, 255), unused);
      end
      default: begin
        push_text("bh");
        r = $urandom_range(0, 9);
        if (r < 6) push_number($urandom_range(0, 6), cnt);
        else if (r < 8) push_number($urandom_range(7, smf_pkg::MAX_PAYLOAD), cnt);
        else if (r == 8) push_number($urandom_range(smf_pkg::MAX_PAYLOAD + 1, 255), cnt);
        else push_number(-1, cnt);
        if (cnt <= smf_pkg::MAX_PAYLOAD) push_random_bytes(int'(cnt));
      end
    endcase
  endtask

  task automatic push_noise(input logic radio);
    case ($urandom_range(0, 2))
      0: push_random_bytes($urandom_range(1, 4));
      1: begin
        if (radio) rx_pending.push_back(smf_pkg::SYNC0);
        else rx_pending.push_back($urandom_range(0, 1) ? smf_pkg::CH_B : smf_pkg::CH_L);
        push_random_bytes($urandom_range(1, 5));
      end
      default: begin
        if (radio) begin
          rx_pending.push_back(smf_pkg::SYNC0);
          rx_pending.push_back(smf_pkg::SYNC1);
        end else begin
          push_text("ls");
        end
        push_random_bytes($urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic fill_random(input logic radio, input int count);
    int start;
    start = rx_pending.size();
    while (rx_pending.size() - start < count) begin
      if ($urandom_range(0, 4) == 0) push_noise(radio);
      else if (radio) push_telegram(-1, $urandom_range(0, 3) != 0);
      else push_command_frame();
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (rx_pending.size() != 0 || in_tvalid || frame_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    fr_mode = m;
    fr_pos = '0;
    fr_sum = '0;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] val;
    logic       mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_text("baia");
    push_text("bs");
    push_number(8'h0A, val);
    push_text("lsFfa9");
    push_text("bh00");
    push_text("bh02");
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    push_text("lszG/:");
    push_text("bh19");
    push_text("bh18");
    rx_pending.push_back(8'hFF);
    push_random_bytes(22);
    rx_pending.push_back(8'h00);
    push_text("xbbaiels1");
    wait_drained();
    write_mode(1'b1);

    @(negedge clk);
    push_telegram(8'h00, 1'b1);
    push_telegram(8'hFF, 1'b1);
    push_telegram(-1, 1'b0);
    rx_pending.push_back(smf_pkg::SYNC0);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h00);
    push_telegram(-1, 1'b1);
    rx_pending.push_back(smf_pkg::SYNC0);
    rx_pending.push_back(smf_pkg::SYNC1);
    rx_pending.push_back(8'h01);
    rx_pending.push_back(8'h02);
    wait_drained();
    write_mode(1'b1);
    @(negedge clk);
    push_telegram(-1, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      mode = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      write_mode(mode);
      @(negedge clk);
      fill_random(mode, 100);
      if (ph == 2 || ph == 5) wait_drained();
      fill_random(mode, 100);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (frame_results.size() != 0)
      report_mismatch("results never produced", frame_results.size(), '0);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: serial_message_framer_core.f
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_in_stage.sv
rtl/core/smf_engine.sv
rtl/core/smf_out_stage.sv
rtl/core/serial_message_framer_core.sv
tb/tb.sv
